>>> rtl/chs_geometry_translation_top_assert.svh
// Assertion macros for the CHS geometry translation block.
// Included by the checker; needs a clock named clock and a reset named reset in scope.
`ifndef CHS_GEOMETRY_TRANSLATION_TOP_ASSERT_SVH
`define CHS_GEOMETRY_TRANSLATION_TOP_ASSERT_SVH

// Concurrent check sampled on the rising clock, off while reset is high.
`define CGT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds at a sampled edge.
`define CGT_ASSERT_NEVER(label, expr, msg) \
   `CGT_ASSERT(label, !(expr), msg)

`endif

>>> rtl/cgt_pkg.sv
// Shared types, constants and the microcode program of the CHS geometry translator.
// No dependencies; imported by every module of the block.
package cgt_pkg;

   localparam int SECT_PER_TRACK = 63;
   localparam int CYL_LIMIT      = 1024;
   localparam int MAX_LOW_HEADS  = 16;
   localparam int DIV_W          = 14;   // 63 * 255 fits in 14 bits
   localparam int CYL_W          = 22;
   localparam int SEARCH_LAST    = 6;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_OFFSET = 2'd1;
   localparam logic [1:0] MODE_REMAP  = 2'd2;
   localparam logic [1:0] MODE_PART   = 2'd3;

   localparam logic [7:0] CSR_NO_REMAP = 8'd0;
   localparam logic [7:0] CSR_FORCED   = 8'd1;

   typedef logic [2:0] step_type;

   localparam step_type ST_IDLE   = 3'd0;
   localparam step_type ST_CHECK  = 3'd1;
   localparam step_type ST_SEARCH = 3'd2;
   localparam step_type ST_SETDIV = 3'd3;
   localparam step_type ST_DIV    = 3'd4;
   localparam step_type ST_FINISH = 3'd5;
   localparam step_type ST_RETURN = 3'd6;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  partition_heads;
      logic [31:0] capacity;
      logic [7:0]  current_heads;
      logic [7:0]  current_sectors;
   } cgt_req_type;

   typedef struct packed {
      logic        success;
      logic        translated;
      logic [21:0] cylinders;
      logic [7:0]  heads;
      logic [7:0]  sectors;
      logic        offset_active;
      logic        remap_active;
   } cgt_rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_SEARCH,
      OP_SETDIV,
      OP_DIVSTEP,
      OP_FINISH
   } cgt_op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_NO_XLATE,
      C_SEARCH_MORE,
      C_DIV_MORE,
      C_OUT_BUSY
   } cgt_cond_type;

   typedef struct packed {
      cgt_op_type   op;
      cgt_cond_type cond;
      step_type     target;
   } cgt_uword_type;

   typedef struct packed {
      cgt_op_type op;
   } cgt_ctl_type;

   typedef struct packed {
      logic req_valid;
      logic no_xlate;
      logic search_more;
      logic div_more;
      logic out_busy;
   } cgt_stat_type;

   // The control program. A step whose condition holds jumps to its target,
   // any other step falls through to the next one.
   function automatic cgt_uword_type ucode_word(input step_type step);
      cgt_uword_type w;
      case (step)
         ST_IDLE:   w = '{OP_LOAD,    C_NO_REQ,      ST_IDLE};
         ST_CHECK:  w = '{OP_NOP,     C_NO_XLATE,    ST_FINISH};
         ST_SEARCH: w = '{OP_SEARCH,  C_SEARCH_MORE, ST_SEARCH};
         ST_SETDIV: w = '{OP_SETDIV,  C_NEVER,       ST_IDLE};
         ST_DIV:    w = '{OP_DIVSTEP, C_DIV_MORE,    ST_DIV};
         ST_FINISH: w = '{OP_FINISH,  C_OUT_BUSY,    ST_FINISH};
         ST_RETURN: w = '{OP_NOP,     C_ALWAYS,      ST_IDLE};
         default:   w = '{OP_NOP,     C_ALWAYS,      ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] head_step(input logic [2:0] idx);
      logic [7:0] h;
      case (idx)
         3'd0:    h = 8'd4;
         3'd1:    h = 8'd8;
         3'd2:    h = 8'd16;
         3'd3:    h = 8'd32;
         3'd4:    h = 8'd64;
         3'd5:    h = 8'd128;
         default: h = 8'd255;
      endcase
      return h;
   endfunction

   // Capacity covered by 1024 cylinders at the given head step.
   function automatic logic [23:0] head_threshold(input logic [2:0] idx);
      logic [23:0] t;
      t = 24'(SECT_PER_TRACK * CYL_LIMIT) * 24'(head_step(idx));
      return t;
   endfunction

   function automatic logic [7:0] believed_heads(input logic [7:0] ph);
      logic [7:0] h;
      if (ph inside {8'd32, 8'd64, 8'd128, 8'd240, 8'd255}) begin
         h = ph;
      end else begin
         h = 8'd0;
      end
      return h;
   endfunction

endpackage

>>> rtl/chs_geometry_translation_top.sv
// CHS geometry translator: takes one request word and returns one result word with the
// translated cylinder/head/sector geometry and the sticky offset and remap flags. A request
// that computes no geometry skips the head search and the divider; one that translates runs
// the serial divider over all CAP_W capacity bits, where CAP_W is the smaller of
// CAPACITY_BITS and 32. The serial divider makes one quotient bit per cycle, and the head
// search tries up to seven head steps. The finished result sits
// in an output register, so a stalled result holds back the next request only at its end.
// Settings are taken at any time on csr_ and must change only while the block is idle.
// Depends on cgt_pkg, cgt_sequencer and cgt_datapath.
module chs_geometry_translation_top
   import cgt_pkg::*;
#(
   parameter int CAPACITY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cgt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output cgt_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   // Only the 32 bits of the capacity field can be used.
   localparam int CAP_W = (CAPACITY_BITS < 32) ? CAPACITY_BITS : 32;

   cgt_ctl_type  ctl;
   cgt_stat_type stat;

   cgt_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   cgt_datapath #(
      .CAP_W (CAP_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .stat      (stat),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

>>> rtl/cgt_sequencer.sv
// Step counter and microcode fetch for the CHS geometry translator.
// Depends on cgt_pkg for the program table and the control and status structs.
module cgt_sequencer
   import cgt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cgt_stat_type stat,
   output cgt_ctl_type  ctl
);

   step_type      step_ff;
   step_type      step_in;
   cgt_uword_type uword;
   logic          jump;

   assign uword  = ucode_word(step_ff);
   assign ctl.op = uword.op;

   always_comb begin
      case (uword.cond)
         C_NEVER:       jump = 1'b0;
         C_ALWAYS:      jump = 1'b1;
         C_NO_REQ:      jump = !stat.req_valid;
         C_NO_XLATE:    jump = stat.no_xlate;
         C_SEARCH_MORE: jump = stat.search_more;
         C_DIV_MORE:    jump = stat.div_more;
         C_OUT_BUSY:    jump = stat.out_busy;
         default:       jump = 1'b1;
      endcase
   end

   always_comb begin
      if (jump) begin
         step_in = uword.target;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> rtl/cgt_datapath.sv
// Datapath of the CHS geometry translator: settings, sticky flags, head search,
// serial divider and result register. Depends on cgt_pkg; driven by cgt_sequencer.
module cgt_datapath
   import cgt_pkg::*;
#(
   parameter int CAP_W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  cgt_ctl_type  ctl,
   output cgt_stat_type stat,
   input  logic         req_valid,
   output logic         req_stall,
   input  cgt_req_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output cgt_rsp_type  rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int CNT_W = $clog2(CAP_W + 1);

   logic no_remap_ff, forced_ff;
   logic offset_ff, offset_in;
   logic remap_ff, remap_in;
   logic success_ff, success_in;
   logic xlate_ff, xlate_in;
   logic [7:0]       bh_ff, cur_h_ff, cur_s_ff, heads_ff;
   logic [CAP_W-1:0] cap_ff, quo_ff;
   logic [2:0]       idx_ff;
   logic [DIV_W-1:0] div_ff, rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   cgt_rsp_type      rsp_ff, rsp_in;

   logic             load, finish;
   logic [7:0]       bh;
   logic [7:0]       heads_sel;
   logic [DIV_W:0]   trial;
   logic             qbit;
   logic [CYL_W-1:0] cyl_sat;

   assign load      = (ctl.op == OP_LOAD) && req_valid;
   assign req_stall = (ctl.op != OP_LOAD);
   assign csr_ready = 1'b1;
   assign bh        = believed_heads(req_data.partition_heads);

   assign stat.req_valid   = req_valid;
   assign stat.no_xlate    = !xlate_ff;
   assign stat.search_more = (idx_ff < 3'(SEARCH_LAST))
                             && (CAP_W'(head_threshold(idx_ff)) < cap_ff);
   assign stat.div_more    = (cnt_ff != CNT_W'(1));
   assign stat.out_busy    = rsp_valid_ff && rsp_stall;

   assign finish = (ctl.op == OP_FINISH) && !stat.out_busy;

   // Flag updates and the translate decision for an accepted word.
   always_comb begin
      offset_in  = offset_ff;
      remap_in   = remap_ff;
      success_in = 1'b0;
      xlate_in   = !forced_ff;
      if (!no_remap_ff) begin
         if (req_data.mode == MODE_OFFSET) begin
            offset_in  = 1'b1;
            success_in = 1'b1;
         end else if (req_data.mode == MODE_REMAP && !remap_ff) begin
            remap_in   = 1'b1;
            success_in = 1'b1;
         end
      end
      if (req_data.mode == MODE_PART && (bh == 8'd0
          || (req_data.current_heads >= bh
              && req_data.current_sectors == 8'(SECT_PER_TRACK)))) begin
         xlate_in = 1'b0;
      end
      if (req_data.mode == MODE_REMAP && req_data.current_heads > 8'(MAX_LOW_HEADS)) begin
         xlate_in = 1'b0;
      end
   end

   assign heads_sel = (bh_ff != 8'd0) ? bh_ff : head_step(idx_ff);

   // One restoring divide step: bring down the next dividend bit.
   assign trial = {rem_ff, quo_ff[CAP_W-1]};
   assign qbit  = (trial >= {1'b0, div_ff});

   assign cyl_sat = (|quo_ff[CAP_W-1:CYL_W]) ? {CYL_W{1'b1}} : quo_ff[CYL_W-1:0];

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.success       = success_ff || xlate_ff;
      rsp_in.translated    = xlate_ff;
      rsp_in.cylinders     = xlate_ff ? cyl_sat : '0;
      rsp_in.heads         = xlate_ff ? heads_ff : cur_h_ff;
      rsp_in.sectors       = xlate_ff ? 8'(SECT_PER_TRACK) : cur_s_ff;
      rsp_in.offset_active = offset_ff;
      rsp_in.remap_active  = remap_ff;
   end

   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         no_remap_ff  <= 1'b0;
         forced_ff    <= 1'b0;
         offset_ff    <= 1'b0;
         remap_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NO_REMAP) begin
               no_remap_ff <= csr_wdata[0];
            end else if (csr_index == CSR_FORCED) begin
               forced_ff <= csr_wdata[0];
            end
         end
         if (load) begin
            offset_ff <= offset_in;
            remap_ff  <= remap_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         success_ff <= success_in;
         xlate_ff   <= xlate_in;
         bh_ff      <= bh;
         cap_ff     <= req_data.capacity[CAP_W-1:0];
         cur_h_ff   <= req_data.current_heads;
         cur_s_ff   <= req_data.current_sectors;
         idx_ff     <= 3'd0;
      end
      if (ctl.op == OP_SEARCH && stat.search_more) begin
         idx_ff <= idx_ff + 3'd1;
      end
      if (ctl.op == OP_SETDIV) begin
         heads_ff <= heads_sel;
         div_ff   <= DIV_W'(SECT_PER_TRACK) * DIV_W'(heads_sel);
         rem_ff   <= '0;
         quo_ff   <= cap_ff;
         cnt_ff   <= CNT_W'(CAP_W);
      end
      if (ctl.op == OP_DIVSTEP) begin
         rem_ff <= qbit ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[CAP_W-2:0], qbit};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/cgt_checker.sv
// Port-level checks for the CHS geometry translator, bound to its top level.
// Depends on cgt_pkg and the assertion macros in chs_geometry_translation_top_assert.svh.
`include "chs_geometry_translation_top_assert.svh"

module cgt_checker
   import cgt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input cgt_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input cgt_rsp_type rsp_data,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [7:0]  csr_index,
   input logic [7:0]  csr_wdata
);

   logic xlate_ok;
   logic stray_cyl;

   assign xlate_ok  = rsp_data.success && (rsp_data.sectors == 8'(SECT_PER_TRACK));
   assign stray_cyl = !rsp_data.translated && (rsp_data.cylinders != '0);

   // A stalled result word stays offered.
   `CGT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result word dropped while stalled")

   // The block works on one word at a time, so an accepted word closes the input.
   `CGT_ASSERT(a_one_at_a_time, req_valid && !req_stall |=> req_stall, "input open right after a word")

   // A translated geometry always has 63 sectors and counts as success.
   `CGT_ASSERT(a_xlate_shape, rsp_valid && rsp_data.translated |-> xlate_ok, "bad translated word")

   // Without translation no cylinder count is reported.
   `CGT_ASSERT_NEVER(a_cyl_zero, rsp_valid && stray_cyl, "cylinders set without translation")

endmodule

bind chs_geometry_translation_top cgt_checker u_checker (.*);

>>> tb/sv/chs_geometry_translation_top_test.sv
// Testbench for chs_geometry_translation_top: directed and random translation requests
// checked word by word against an in-bench predictor. Depends on cgt_pkg and the block.
`timescale 1ns / 1ps

module chs_geometry_translation_top_test;
   import cgt_pkg::*;

   localparam int CAP_BITS = 32;
   localparam int HOLD_CYCLES = 400;
   // The slowest item is a translation plus the longest driver gap and receiver stall;
   // the long receiver hold is the longest quiet stretch. The limit covers it many times.
   localparam int QUIET_LIMIT = 20000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 153;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cgt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cgt_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   chs_geometry_translation_top #(.CAPACITY_BITS(CAP_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: configuration copy and the two sticky flags.
   bit cfg_no_remap = 1'b0;
   bit cfg_forced = 1'b0;
   bit offset_seen = 1'b0;
   bit remap_seen = 1'b0;

   cgt_req_type pending_requests[$];
   cgt_rsp_type expected_geometry[$];
   int results_owed = 0;
   int mismatch_count = 0;
   bit idling_on = 1'b1;
   bit hold_request = 1'b0;

   function automatic cgt_rsp_type predict_translation(input cgt_req_type r);
      logic [7:0]  ph;
      logic [7:0]  hd;
      logic [63:0] cap;
      logic [63:0] cyl;
      bit          xlate;
      cgt_rsp_type o;
      case (r.partition_heads)
         8'd32, 8'd64, 8'd128, 8'd240, 8'd255: ph = r.partition_heads;
         default: ph = 8'd0;
      endcase
      cap = 64'(r.capacity) & ((64'd1 << CAP_BITS) - 64'd1);
      o = '0;
      cyl = '0;
      hd = r.current_heads;
      xlate = !cfg_forced;
      if (!cfg_no_remap) begin
         if (r.mode == MODE_OFFSET) begin
            offset_seen = 1'b1;
            o.success = 1'b1;
         end else if (r.mode == MODE_REMAP && !remap_seen) begin
            remap_seen = 1'b1;
            o.success = 1'b1;
         end
      end
      if (r.mode == MODE_PART && (ph == 8'd0 ||
          (r.current_heads >= ph && r.current_sectors == 8'(SECT_PER_TRACK))))
         xlate = 1'b0;
      if (r.mode == MODE_REMAP && r.current_heads > 8'(MAX_LOW_HEADS))
         xlate = 1'b0;
      o.sectors = r.current_sectors;
      if (xlate) begin
         if (ph != 8'd0) begin
            hd = ph;
         end else begin
            // Double the heads until 1024 cylinders cover the disk; 255 is the last step.
            hd = 8'd4;
            while (hd != 8'd255 && 64'(SECT_PER_TRACK * CYL_LIMIT) * hd < cap)
               hd = (hd == 8'd128) ? 8'd255 : hd << 1;
         end
         cyl = cap / (64'(SECT_PER_TRACK) * hd);
         if (cyl > 64'd4194303)
            cyl = 64'd4194303;
         o.sectors = 8'(SECT_PER_TRACK);
         o.success = 1'b1;
      end
      o.translated = xlate;
      o.cylinders = cyl[21:0];
      o.heads = hd;
      o.offset_active = offset_seen;
      o.remap_active = remap_seen;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Driver: holds each word until it is taken, with random gaps between words while idling is on.
   bit drv_busy;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         drv_busy = req_valid;
         if (req_valid && !req_stall) begin
            expected_geometry.push_back(predict_translation(req_data));
            drv_busy = 1'b0;
         end
         if (!drv_busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 18) - 1;
            end else if (pending_requests.size() > 0) begin
               req_data <= pending_requests.pop_front();
               drv_busy = 1'b1;
            end
         end
         req_valid <= drv_busy;
      end
   end

   // Receiver stall: random bursts while idling is on, plus one long hold asked for by the stimulus.
   int stall_left = 0;
   int hold_left = 0;
   bit stall_next;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // Monitor: every result word is matched against the oldest prediction.
   cgt_rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_geometry.size() == 0) begin
            report_mismatch("unexpected result word", rsp_data, 0);
         end else begin
            want = expected_geometry.pop_front();
            if (rsp_data.success !== want.success)
               report_mismatch("success", rsp_data.success, want.success);
            if (rsp_data.translated !== want.translated)
               report_mismatch("translated", rsp_data.translated, want.translated);
            if (rsp_data.cylinders !== want.cylinders)
               report_mismatch("cylinders", rsp_data.cylinders, want.cylinders);
            if (rsp_data.heads !== want.heads)
               report_mismatch("heads", rsp_data.heads, want.heads);
            if (rsp_data.sectors !== want.sectors)
               report_mismatch("sectors", rsp_data.sectors, want.sectors);
            if (rsp_data.offset_active !== want.offset_active)
               report_mismatch("offset_active", rsp_data.offset_active, want.offset_active);
            if (rsp_data.remap_active !== want.remap_active)
               report_mismatch("remap_active", rsp_data.remap_active, want.remap_active);
         end
         results_owed--;
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic cgt_req_type make_request(input logic [1:0] mode, input logic [7:0] ph,
                                                input logic [31:0] cap, input logic [7:0] ch,
                                                input logic [7:0] cs);
      cgt_req_type r;
      r.mode = mode;
      r.partition_heads = ph;
      r.capacity = cap;
      r.current_heads = ch;
      r.current_sectors = cs;
      return r;
   endfunction

   function automatic cgt_req_type random_request();
      cgt_req_type r;
      int steps;
      r.mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0, 1: begin
            case ($urandom_range(0, 4))
               0: r.partition_heads = 8'd32;
               1: r.partition_heads = 8'd64;
               2: r.partition_heads = 8'd128;
               3: r.partition_heads = 8'd240;
               default: r.partition_heads = 8'd255;
            endcase
         end
         2: r.partition_heads = 8'd0;
         default: r.partition_heads = 8'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0: r.capacity = $urandom;
         1: r.capacity = $urandom_range(0, 300000);
         2: begin
            // Land on or next to a head-step boundary of the search.
            steps = 4 << $urandom_range(0, 5);
            r.capacity = 32'(SECT_PER_TRACK * CYL_LIMIT * steps + int'($urandom_range(0, 4)) - 2);
         end
         3: r.capacity = $urandom_range(258048, 16515072);
         4: r.capacity = 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: r.capacity = $urandom >> $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 3))
         0: r.current_heads = 8'($urandom_range(0, 16));
         1: r.current_heads = 8'd17;
         2: r.current_heads = 8'($urandom);
         default: r.current_heads = r.partition_heads + 8'($urandom_range(0, 2)) - 8'd1;
      endcase
      r.current_sectors = $urandom_range(0, 1) ? 8'(SECT_PER_TRACK) : 8'($urandom);
      return r;
   endfunction

   task automatic queue_request(input cgt_req_type r);
      pending_requests.push_back(r);
      results_owed++;
   endtask

   task automatic wait_idle();
      while (results_owed != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input bit val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= {7'd0, val};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_NO_REMAP)
         cfg_no_remap = val;
      else if (idx == CSR_FORCED)
         cfg_forced = val;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Remapping disabled: offset and remap requests must leave both flags clear.
      csr_write(CSR_NO_REMAP, 1'b1);
      csr_write(CSR_FORCED, 1'b0);
      queue_request(make_request(MODE_OFFSET, 8'd0, 32'd1000000, 8'd16, 8'd63));
      queue_request(make_request(MODE_REMAP, 8'd0, 32'd0, 8'd4, 8'd17));
      queue_request(make_request(MODE_PLAIN, 8'd0, 32'd0, 8'd0, 8'd0));
      queue_request(make_request(MODE_PART, 8'd255, 32'hFFFF_FFFF, 8'd255, 8'd255));
      wait_idle();

      csr_write(CSR_NO_REMAP, 1'b0);
      // The first remap succeeds, the second only through translation, the third not at all.
      queue_request(make_request(MODE_REMAP, 8'd0, 32'd258048, 8'd16, 8'd63));
      queue_request(make_request(MODE_REMAP, 8'd0, 32'd258049, 8'd16, 8'd63));
      queue_request(make_request(MODE_REMAP, 8'd0, 32'd500, 8'd17, 8'd63));
      queue_request(make_request(MODE_OFFSET, 8'd0, 32'd258049, 8'd1, 8'd1));
      queue_request(make_request(MODE_OFFSET, 8'd0, 32'd8257536, 8'd2, 8'd2));
      queue_request(make_request(MODE_PLAIN, 8'd0, 32'd8257537, 8'd0, 8'd0));
      queue_request(make_request(MODE_PLAIN, 8'd0, 32'hFFFF_FFFF, 8'd255, 8'd255));
      queue_request(make_request(MODE_PLAIN, 8'd240, 32'hFFFF_FFFF, 8'd3, 8'd3));
      queue_request(make_request(MODE_PLAIN, 8'd32, 32'hFFFF_FFFF, 8'd200, 8'd9));
      queue_request(make_request(MODE_PART, 8'd0, 32'd1000, 8'd4, 8'd63));
      queue_request(make_request(MODE_PART, 8'd31, 32'd1000, 8'd4, 8'd63));
      queue_request(make_request(MODE_PART, 8'd64, 32'd5000000, 8'd64, 8'd63));
      queue_request(make_request(MODE_PART, 8'd64, 32'd5000000, 8'd63, 8'd63));
      queue_request(make_request(MODE_PART, 8'd128, 32'd5000000, 8'd200, 8'd62));
      queue_request(make_request(MODE_PART, 8'd255, 32'd0, 8'd0, 8'd0));
      queue_request(make_request(MODE_REMAP, 8'd128, 32'd9000000, 8'd0, 8'd0));
      queue_request(make_request(MODE_OFFSET, 8'd64, 32'd1, 8'd255, 8'd255));
      wait_idle();

      csr_write(CSR_FORCED, 1'b1);
      queue_request(make_request(MODE_PLAIN, 8'd0, 32'd1000000, 8'd5, 8'd7));
      queue_request(make_request(MODE_PART, 8'd32, 32'd1000000, 8'd1, 8'd1));
      queue_request(make_request(MODE_OFFSET, 8'd0, 32'd1, 8'd2, 8'd3));
      queue_request(make_request(MODE_REMAP, 8'd0, 32'd1, 8'd0, 8'd255));
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin csr_write(CSR_NO_REMAP, 1'b0); csr_write(CSR_FORCED, 1'b0); end
            1: begin csr_write(CSR_NO_REMAP, 1'b1); csr_write(CSR_FORCED, 1'b0); end
            2: begin csr_write(CSR_NO_REMAP, 1'b0); csr_write(CSR_FORCED, 1'b1); end
            3: begin csr_write(CSR_NO_REMAP, 1'b1); csr_write(CSR_FORCED, 1'b1); end
            RANDOM_PHASES - 1: begin
               csr_write(CSR_NO_REMAP, 1'b0);
               csr_write(CSR_FORCED, 1'b0);
            end
            default: begin
               csr_write(CSR_NO_REMAP, 1'($urandom_range(0, 1)));
               csr_write(CSR_FORCED, 1'($urandom_range(0, 1)));
            end
         endcase
         // The final phase runs at full rate on both sides.
         if (p == RANDOM_PHASES - 1)
            idling_on = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_request(random_request());
         // Hold the receiver long enough that the block backs up and stalls its input.
         if (p == 0)
            hold_request = 1'b1;
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_geometry.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
